// ===== rtl/kes_pkg.sv =====
// kes_pkg: shared types and constants for the key event sorter
// no dependencies; imported by the interfaces and every module of the block
package kes_pkg;

  // operation codes carried on the input word
  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_POP   = 2'd1,
    OP_CLAIM = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE     = 3'd6;

  // register reset values
  localparam logic [7:0] RST_PRESSED  = 8'd8;
  localparam logic [7:0] RST_RELEASED = 8'd10;
  localparam logic [7:0] RST_UP       = 8'd128;
  localparam logic [7:0] RST_DOWN     = 8'd129;
  localparam logic [7:0] RST_ESCAPE   = 8'd27;
  localparam logic [7:0] RST_DELETE   = 8'd8;
  localparam logic [7:0] RST_NONE     = 8'd0;

  // translation constants
  localparam logic [7:0] RAW_CRSR_UP   = 8'hB6;
  localparam logic [7:0] RAW_CRSR_DOWN = 8'hB7;
  localparam logic [7:0] ASC_STOP      = 8'h03;
  localparam logic [7:0] ASC_DELETE    = 8'h08;
  localparam logic [7:0] ASC_LOWER_A   = 8'h61;
  localparam logic [7:0] ASC_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'd32;
  localparam int unsigned FLAG_MOD_BIT = 7;

  localparam int unsigned PAYLOAD_W = 64;
  localparam logic [2:0] WAIT_MAX = 3'd7;

  typedef struct packed {
    logic [7:0] pressed_type;
    logic [7:0] released_type;
    logic [7:0] code_up;
    logic [7:0] code_down;
    logic [7:0] code_escape;
    logic [7:0] code_delete;
    logic [7:0] code_none;
  } cfg_t;

  // ring control and status between the top level and the ring
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [2:0] waiting;
  } ring_sts_t;

endpackage

// ===== rtl/kes_if.sv =====
// kes_if: valid/ready channel interfaces for input words and result words
// depends on kes_pkg for payload widths
interface kes_in_if (input logic clk);
  import kes_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [7:0]           event_type;
  logic [7:0]           key_flags;
  logic [7:0]           key_raw;
  logic [7:0]           key_ascii;
  logic [PAYLOAD_W-1:0] event_payload;

  modport source (input clk, input ready,
                  output valid, op, event_type, key_flags, key_raw, key_ascii, event_payload);
  modport sink   (input clk, input valid, op, event_type, key_flags, key_raw, key_ascii,
                  event_payload, output ready);
endinterface

interface kes_out_if (input logic clk);
  import kes_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 key_valid;
  logic [7:0]           key_code;
  logic                 key_dropped;
  logic [2:0]           keys_waiting;
  logic                 held_valid;
  logic [7:0]           held_type;
  logic [PAYLOAD_W-1:0] held_payload;
  logic [7:0]           lost_count;

  modport source (input clk, input ready,
                  output valid, key_valid, key_code, key_dropped, keys_waiting,
                  held_valid, held_type, held_payload, lost_count);
  modport sink   (input clk, input valid, key_valid, key_code, key_dropped, keys_waiting,
                  held_valid, held_type, held_payload, lost_count, output ready);
endinterface

// ===== rtl/key_event_sorter_fifo.sv =====
// key_event_sorter_fifo: top level of the keyboard event sorter
// depends on kes_pkg, kes_in_if/kes_out_if, kes_xlate and kes_ring
//
//  channel   dir  handshake             word contents
//  in_if     in   valid/ready           op, event_type, key_flags, key_raw, key_ascii,
//                                        event_payload
//  out_if    out  valid/ready           key_valid, key_code, key_dropped, keys_waiting,
//                                        held_valid, held_type, held_payload, lost_count
//  cfg_*     in   write enable only     cfg_idx selects register, cfg_wdata 8 bits
//
// each input word is handled in order: accept (ring write or read issue), then in the
// response state the ring memory's registered read data is folded into the result register
// a new word is accepted once the sequencer is idle and the result register is empty or being taken that cycle
// out_if stalls hold the result register and block further input
// rst_n is synchronous; indexes, held-ready flag, lost counter and config reset at once,
// the ring memory needs no clearing pass
module key_event_sorter_fifo #(
  parameter int RING_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  kes_in_if.sink                            in_if,
  kes_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [kes_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [kes_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import kes_pkg::*;

  // one-hot sequencer
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  cfg_t cfg_r;

  // held event slot
  logic [7:0]           held_type_r;
  logic [PAYLOAD_W-1:0] held_data_r;
  logic                 held_ready_r, held_ready_nxt;
  logic [7:0]           lost_r, lost_nxt;

  // per-word flags carried from accept to response
  logic pend_kvalid_r, pend_drop_r, pend_hvalid_r;

  // result register
  logic                 out_valid_r;
  logic                 o_key_valid_r;
  logic [7:0]           o_key_code_r;
  logic                 o_key_dropped_r;
  logic [2:0]           o_waiting_r;
  logic                 o_held_valid_r;
  logic [7:0]           o_held_type_r;
  logic [PAYLOAD_W-1:0] o_held_payload_r;
  logic [7:0]           o_lost_r;

  logic       in_fire, out_fire;
  op_e        op;
  logic       is_press, is_release, key_ok, take_held;
  logic [7:0] xcode;
  logic [7:0] rdata;
  ring_ctl_t  ring_ctl;
  ring_sts_t  ring_sts;
  logic       push_req;

  assign op       = op_e'(in_if.op);
  assign out_fire = out_valid_r && out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign in_fire  = in_if.valid && in_if.ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_type  <= RST_PRESSED;
      cfg_r.released_type <= RST_RELEASED;
      cfg_r.code_up       <= RST_UP;
      cfg_r.code_down     <= RST_DOWN;
      cfg_r.code_escape   <= RST_ESCAPE;
      cfg_r.code_delete   <= RST_DELETE;
      cfg_r.code_none     <= RST_NONE;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PRESSED:  cfg_r.pressed_type  <= cfg_wdata;
        CFG_RELEASED: cfg_r.released_type <= cfg_wdata;
        CFG_UP:       cfg_r.code_up       <= cfg_wdata;
        CFG_DOWN:     cfg_r.code_down     <= cfg_wdata;
        CFG_ESCAPE:   cfg_r.code_escape   <= cfg_wdata;
        CFG_DELETE:   cfg_r.code_delete   <= cfg_wdata;
        CFG_NONE:     cfg_r.code_none     <= cfg_wdata;
        default:      ;   // index beyond the list is ignored
      endcase
    end
  end

  kes_xlate u_xlate (
    .cfg       (cfg_r),
    .key_raw   (in_if.key_raw),
    .key_ascii (in_if.key_ascii),
    .code      (xcode)
  );

  // sort the arriving event; pressed wins over released when both match
  assign is_press   = (in_if.event_type == cfg_r.pressed_type);
  assign is_release = (in_if.event_type == cfg_r.released_type);
  assign key_ok     = is_press && !in_if.key_flags[FLAG_MOD_BIT] && (xcode != cfg_r.code_none);
  assign take_held  = !is_press && !is_release;
  assign push_req   = in_fire && (op == OP_EVENT) && key_ok;

  always_comb begin
    ring_ctl.push  = push_req && !ring_sts.full;
    ring_ctl.pop   = in_fire && (op == OP_POP) && !ring_sts.empty;
    ring_ctl.clear = in_fire && (op == OP_CLEAR);
  end

  kes_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .wdata (xcode),
    .rdata (rdata),
    .sts   (ring_sts)
  );

  // held slot and lost counter
  always_comb begin
    held_ready_nxt = held_ready_r;
    lost_nxt       = lost_r;
    if (in_fire) begin
      case (op)
        OP_EVENT: begin
          if (take_held) begin
            if (held_ready_r) lost_nxt = lost_r + 8'd1;   // unclaimed event overwritten
            held_ready_nxt = 1'b1;
          end
        end
        OP_CLAIM: held_ready_nxt = 1'b0;
        OP_CLEAR: begin
          held_ready_nxt = 1'b0;
          lost_nxt       = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_ready_r <= 1'b0;
      lost_r       <= '0;
      held_type_r  <= '0;
      held_data_r  <= '0;
    end else begin
      held_ready_r <= held_ready_nxt;
      lost_r       <= lost_nxt;
      if (in_fire && (op == OP_EVENT) && take_held) begin
        held_type_r <= in_if.event_type;
        held_data_r <= in_if.event_payload;
      end
    end
  end

  // sequencer: accept, then build the result from the ring read data
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pend_kvalid_r <= 1'b0;
      pend_drop_r   <= 1'b0;
      pend_hvalid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        pend_kvalid_r <= ring_ctl.pop;
        pend_drop_r   <= push_req && ring_sts.full;
        pend_hvalid_r <= (op == OP_CLAIM) && held_ready_r;
      end
      if (state_r == S_RESP) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; held slot is untouched by a claim, so it is read here directly
  always_ff @(posedge clk) begin
    if (state_r == S_RESP) begin
      o_key_valid_r    <= pend_kvalid_r;
      o_key_code_r     <= pend_kvalid_r ? rdata : 8'd0;
      o_key_dropped_r  <= pend_drop_r;
      o_waiting_r      <= ring_sts.waiting;
      o_held_valid_r   <= pend_hvalid_r;
      o_held_type_r    <= pend_hvalid_r ? held_type_r : 8'd0;
      o_held_payload_r <= pend_hvalid_r ? held_data_r : '0;
      o_lost_r         <= lost_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.key_valid    = o_key_valid_r;
  assign out_if.key_code     = o_key_code_r;
  assign out_if.key_dropped  = o_key_dropped_r;
  assign out_if.keys_waiting = o_waiting_r;
  assign out_if.held_valid   = o_held_valid_r;
  assign out_if.held_type    = o_held_type_r;
  assign out_if.held_payload = o_held_payload_r;
  assign out_if.lost_count   = o_lost_r;

  a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_RESP)) else $error("accepted word did not reach response");
  a_resp_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |=> out_valid_r) else $error("response not loaded");
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_key_valid_r && o_held_valid_r)) else $error("pop and claim together");
  a_resp_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |-> !out_valid_r) else $error("result register overrun");

endmodule

// ===== rtl/kes_xlate.sv =====
// kes_xlate: maps a raw scan code and ascii value to a queued key code
// depends on kes_pkg (cfg_t and translation constants)
module kes_xlate (
  input  kes_pkg::cfg_t cfg,
  input  logic [7:0]    key_raw,
  input  logic [7:0]    key_ascii,
  output logic [7:0]    code
);
  import kes_pkg::*;

  always_comb begin
    if (key_raw == RAW_CRSR_UP) begin
      code = cfg.code_up;
    end else if (key_raw == RAW_CRSR_DOWN) begin
      code = cfg.code_down;
    end else if (key_ascii == ASC_STOP) begin
      code = cfg.code_escape;
    end else if (key_ascii == ASC_DELETE) begin
      code = cfg.code_delete;
    end else if (key_ascii inside {[ASC_LOWER_A:ASC_LOWER_Z]}) begin
      code = key_ascii - CASE_OFFSET;   // fold to upper case
    end else begin
      code = key_ascii;
    end
  end

endmodule

// ===== rtl/kes_ring.sv =====
// kes_ring: key ring memory with write and read indexes, one slot kept free
// depends on kes_pkg (ring_ctl_t, ring_sts_t)
module kes_ring #(
  parameter int RING_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kes_pkg::ring_ctl_t  ctl,
  input  logic [7:0]          wdata,
  output logic [7:0]          rdata,
  output kes_pkg::ring_sts_t  sts
);
  import kes_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int DIFF_W = IDX_W + 3;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  logic [7:0]       mem [RING_DEPTH];
  logic [7:0]       rdata_r;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_inc, rd_inc;
  logic [DIFF_W-1:0] diff;

  assign wr_inc = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
  assign rd_inc = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + 1'b1;

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    if (ctl.clear) begin
      wr_idx_nxt = '0;
      rd_idx_nxt = '0;
    end else begin
      if (ctl.push) wr_idx_nxt = wr_inc;
      if (ctl.pop)  rd_idx_nxt = rd_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.push) mem[wr_idx_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) rdata_r <= mem[rd_idx_r];
  end

  assign rdata = rdata_r;

  // occupancy, saturating at seven
  always_comb begin
    if (wr_idx_r >= rd_idx_r) begin
      diff = DIFF_W'(wr_idx_r) - DIFF_W'(rd_idx_r);
    end else begin
      diff = DIFF_W'(wr_idx_r) + DIFF_W'(RING_DEPTH) - DIFF_W'(rd_idx_r);
    end
  end

  assign sts.empty   = (wr_idx_r == rd_idx_r);
  assign sts.full    = (wr_inc == rd_idx_r);
  assign sts.waiting = (diff > DIFF_W'(WAIT_MAX)) ? WAIT_MAX : diff[2:0];

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !sts.full) else $error("push into full ring");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !sts.empty) else $error("pop from empty ring");
  a_push_moves_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && !ctl.clear) |=> (wr_idx_r != $past(wr_idx_r)))
    else $error("write index did not advance on push");

endmodule
